### rtl/core/dlcb_pkg.sv
// Package: shared constants, types and FSM encoding for the cross-basis FIR bank
`timescale 1ns / 1ps
`default_nettype none
package dlcb_pkg;
  localparam int NUM_VARS      = 4;
  localparam int NUM_LAG_BASES = 4;
  localparam int HISTORY_DEPTH = 512;
  localparam int SAMPLE_BITS   = 16;
  localparam int ACC_BITS      = 40;
  localparam int PROD_BITS     = 2 * SAMPLE_BITS;
  localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
  localparam int FILL_BITS     = $clog2(HISTORY_DEPTH + 1);
  localparam int LAG_BITS      = 9;
  localparam int VAR_BITS      = 2;
  localparam int BASIS_BITS    = 2;
  localparam int NUM_MACS      = NUM_VARS * NUM_LAG_BASES;
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_LAG = 3'd0;
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] lane_t;
  typedef logic signed [ACC_BITS-1:0] acc_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MAC, ST_DRAIN, ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic                 load_wr;    // write coefficient row
    logic                 hist_wr;    // push sample row
    logic                 clear_acc;
    logic                 rd_en;      // issue tap read
    logic                 mac_en;     // accumulate registered read data
    logic [ADDR_BITS-1:0] tap;
    logic                 emit_load;  // capture one result into output reg
    logic [VAR_BITS-1:0]  var_sel;
    logic [BASIS_BITS-1:0] basis_sel;
    logic                 valid_res;
    logic                 last;
  } dp_cmd_t;

  function automatic acc_t sat_add(acc_t a, logic signed [PROD_BITS-1:0] p);
    logic signed [ACC_BITS:0] s;
    s = {a[ACC_BITS-1], a} + {{(ACC_BITS + 1 - PROD_BITS){p[PROD_BITS-1]}}, p};
    if (s[ACC_BITS] != s[ACC_BITS-1])
      return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    return s[ACC_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/dlcb_if.sv
// Interfaces: input request and output result channels
`timescale 1ns / 1ps
`default_nettype none
interface dlcb_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [8:0] tap_index;
  logic signed [15:0] lane_0, lane_1, lane_2, lane_3;
  modport source (output valid, func, tap_index, lane_0, lane_1, lane_2, lane_3, input ready);
  modport sink (input valid, func, tap_index, lane_0, lane_1, lane_2, lane_3, output ready);
endinterface

interface dlcb_out_if;
  logic valid;
  logic ready;
  logic signed [39:0] acc_value;
  logic [1:0] var_index;
  logic [1:0] basis_index;
  logic valid_res;
  logic last;
  modport source (output valid, acc_value, var_index, basis_index, valid_res, last,
                  input ready);
  modport sink (input valid, acc_value, var_index, basis_index, valid_res, last,
                output ready);
endinterface
`default_nettype wire

### rtl/core/distributed_lag_cross_basis.sv
// Top level: cross-basis FIR bank with APB config port
//  channel | dir | handshake           | payload
//  in_     | in  | valid/ready         | func, tap_index, lane_0..3
//  out_    | out | valid/ready         | acc_value, var/basis index, valid_res, last
//  cfg_    | in  | APB, pready=1       | max_lag at address 0
// A load request writes one coefficient row. A sample request sweeps taps 0..max_lag
// (one read of both memories per tap, 16 MACs in parallel), drains the pipeline, then
// emits 16 results.
// Reset is synchronous active low; memories are not cleared.
// Output stalls hold the result register and the emit sequence.
`timescale 1ns / 1ps
`default_nettype none
module distributed_lag_cross_basis (
  input  wire logic clk,
  input  wire logic rst_n,
  dlcb_in_if.sink   in_ch,
  dlcb_out_if.source out_ch,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [dlcb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic [dlcb_pkg::LAG_BITS-1:0] max_lag_r;
  logic in_acc, out_take, res_full;
  logic [dlcb_pkg::ADDR_BITS-1:0] wr_slot, now_slot;
  dlcb_pkg::dp_cmd_t cmd;
  dlcb_pkg::lane_t lanes [4];

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_lag_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == dlcb_pkg::REG_MAX_LAG)
      max_lag_r <= cfg_pwdata[dlcb_pkg::LAG_BITS-1:0];
  end
  assign cfg_prdata = (cfg_paddr == dlcb_pkg::REG_MAX_LAG) ?
                      {{(32 - dlcb_pkg::LAG_BITS){1'b0}}, max_lag_r} : 32'd0;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;
  assign lanes[0] = in_ch.lane_0;
  assign lanes[1] = in_ch.lane_1;
  assign lanes[2] = in_ch.lane_2;
  assign lanes[3] = in_ch.lane_3;

  dlcb_ctrl u_ctrl (
    .clk, .rst_n, .in_acc, .in_func(in_ch.func), .in_tap(in_ch.tap_index),
    .max_lag(max_lag_r), .res_full, .out_take, .in_ready(in_ch.ready),
    .wr_slot, .now_slot, .cmd(cmd)
  );

  dlcb_datapath u_dp (
    .clk, .cmd, .wr_slot, .now_slot, .lane_in(lanes), .out_take, .res_full,
    .res_acc(out_ch.acc_value), .res_var(out_ch.var_index),
    .res_basis(out_ch.basis_index), .res_valid(out_ch.valid_res),
    .res_last(out_ch.last), .rst_n
  );
  assign out_ch.valid = res_full;
endmodule
`default_nettype wire

### rtl/core/dlcb_datapath.sv
// Datapath: coefficient/history memories, 16 MAC lanes, result register
`timescale 1ns / 1ps
`default_nettype none
module dlcb_datapath (
  input  wire logic               clk,
  input  wire dlcb_pkg::dp_cmd_t  cmd,
  input  wire logic [dlcb_pkg::ADDR_BITS-1:0] wr_slot,
  input  wire logic [dlcb_pkg::ADDR_BITS-1:0] now_slot,
  input  wire dlcb_pkg::lane_t    lane_in [4],
  input  wire logic               out_take,
  output logic                    res_full,
  output dlcb_pkg::acc_t          res_acc,
  output logic [dlcb_pkg::VAR_BITS-1:0]   res_var,
  output logic [dlcb_pkg::BASIS_BITS-1:0] res_basis,
  output logic                    res_valid,
  output logic                    res_last,
  input  wire logic               rst_n
);
  localparam int RW = dlcb_pkg::SAMPLE_BITS * 4;
  localparam int SB = dlcb_pkg::SAMPLE_BITS;
  logic [RW-1:0] coef_mem [dlcb_pkg::HISTORY_DEPTH];
  logic [RW-1:0] hist_mem [dlcb_pkg::HISTORY_DEPTH];
  logic [RW-1:0] coef_q_r, hist_q_r;
  logic [RW-1:0] wrow;
  logic [dlcb_pkg::ADDR_BITS-1:0] hslot;
  dlcb_pkg::acc_t acc_r [dlcb_pkg::NUM_MACS];
  logic signed [dlcb_pkg::PROD_BITS-1:0] prod_r [dlcb_pkg::NUM_MACS];
  logic prod_v_r;

  assign wrow  = {lane_in[3], lane_in[2], lane_in[1], lane_in[0]};
  assign hslot = now_slot - cmd.tap;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) coef_mem[cmd.tap] <= wrow;
    if (cmd.rd_en) coef_q_r <= coef_mem[cmd.tap];
  end
  always_ff @(posedge clk) begin
    if (cmd.hist_wr) hist_mem[wr_slot] <= wrow;
    if (cmd.rd_en) hist_q_r <= hist_mem[hslot];
  end

  // stage: products registered, then accumulate
  always_ff @(posedge clk) begin
    for (int v = 0; v < dlcb_pkg::NUM_VARS; v++)
      for (int b = 0; b < dlcb_pkg::NUM_LAG_BASES; b++)
        prod_r[v*dlcb_pkg::NUM_LAG_BASES+b] <=
          $signed(hist_q_r[v*SB +: SB]) * $signed(coef_q_r[b*SB +: SB]);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else prod_v_r <= cmd.mac_en;
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < dlcb_pkg::NUM_MACS; i++) begin
      if (cmd.clear_acc) acc_r[i] <= '0;
      else if (prod_v_r) acc_r[i] <= dlcb_pkg::sat_add(acc_r[i], prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_full <= 1'b0;
    else if (cmd.emit_load) res_full <= 1'b1;
    else if (out_take) res_full <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      res_acc   <= cmd.valid_res ? acc_r[{cmd.var_sel, cmd.basis_sel}] : '0;
      res_var   <= cmd.var_sel;
      res_basis <= cmd.basis_sel;
      res_valid <= cmd.valid_res;
      res_last  <= cmd.last;
    end
  end
endmodule
`default_nettype wire

### rtl/core/dlcb_ctrl.sv
// Controller: sequences loads, tap sweep and result emission
`timescale 1ns / 1ps
`default_nettype none
module dlcb_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_acc,
  input  wire logic in_func,
  input  wire logic [8:0] in_tap,
  input  wire logic [dlcb_pkg::LAG_BITS-1:0] max_lag,
  input  wire logic res_full,
  input  wire logic out_take,
  output logic      in_ready,
  output logic [dlcb_pkg::ADDR_BITS-1:0] wr_slot,
  output logic [dlcb_pkg::ADDR_BITS-1:0] now_slot,
  output dlcb_pkg::dp_cmd_t cmd
);
  dlcb_pkg::state_t state_r, state_nxt;
  logic [dlcb_pkg::ADDR_BITS-1:0] wp_r, wp_nxt, now_r, now_nxt;
  logic [dlcb_pkg::FILL_BITS-1:0] fill_r, fill_nxt;
  logic [dlcb_pkg::LAG_BITS-1:0] lag_r, lag_nxt, k_r, k_nxt;
  logic [1:0] drain_r, drain_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  logic       emit_ok;
  logic       rd_d_r;

  assign wr_slot  = wp_r;
  assign now_slot = now_r;
  assign emit_ok  = !res_full || out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlcb_pkg::ST_IDLE; wp_r <= '0; fill_r <= '0;
      now_r <= '0; lag_r <= '0; k_r <= '0; drain_r <= '0; idx_r <= '0; vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt; wp_r <= wp_nxt; fill_r <= fill_nxt;
      now_r <= now_nxt; lag_r <= lag_nxt; k_r <= k_nxt; drain_r <= drain_nxt;
      idx_r <= idx_nxt; vld_r <= vld_nxt;
    end
  end

  // product pipeline: mac_en marks the cycle when read data is valid
  always_ff @(posedge clk) begin
    if (!rst_n) rd_d_r <= 1'b0;
    else rd_d_r <= (state_r == dlcb_pkg::ST_MAC);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dlcb_pkg::ST_IDLE:
        if (in_acc && in_func == dlcb_pkg::FUNC_SAMPLE)
          state_nxt = dlcb_pkg::ST_MAC;
      dlcb_pkg::ST_MAC:   if (k_r == lag_r) state_nxt = dlcb_pkg::ST_DRAIN;
      dlcb_pkg::ST_DRAIN: if (drain_r == 2'd2) state_nxt = dlcb_pkg::ST_EMIT;
      dlcb_pkg::ST_EMIT:  if (emit_ok && idx_r == 4'd15) state_nxt = dlcb_pkg::ST_IDLE;
      default:            state_nxt = dlcb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt = wp_r; fill_nxt = fill_r; now_nxt = now_r; lag_nxt = lag_r;
    k_nxt = k_r; drain_nxt = drain_r; idx_nxt = idx_r; vld_nxt = vld_r;
    in_ready = (state_r == dlcb_pkg::ST_IDLE);
    cmd = '0;
    unique case (state_r)
      dlcb_pkg::ST_IDLE: begin
        cmd.tap = in_tap;
        if (in_acc) begin
          if (in_func == dlcb_pkg::FUNC_LOAD) cmd.load_wr = 1'b1;
          else begin
            cmd.hist_wr = 1'b1;
            cmd.clear_acc = 1'b1;
            now_nxt = wp_r;
            wp_nxt = wp_r + 1'b1;
            if (fill_r < dlcb_pkg::FILL_BITS'(dlcb_pkg::HISTORY_DEPTH))
              fill_nxt = fill_r + 1'b1;
            lag_nxt = max_lag;
            vld_nxt = fill_r >= {1'b0, max_lag};
            k_nxt = '0; drain_nxt = '0; idx_nxt = '0;
          end
        end
      end
      dlcb_pkg::ST_MAC: begin
        cmd.tap = k_r[dlcb_pkg::ADDR_BITS-1:0];
        cmd.rd_en = 1'b1;
        k_nxt = k_r + 1'b1;
      end
      dlcb_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
      end
      dlcb_pkg::ST_EMIT: begin
        cmd.var_sel = idx_r[3:2];
        cmd.basis_sel = idx_r[1:0];
        cmd.valid_res = vld_r;
        cmd.last = (idx_r == 4'd15);
        if (emit_ok) begin
          cmd.emit_load = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: ;
    endcase
    // read data is valid in the cycle after rd_en; products follow
    cmd.mac_en = rd_d_r;
  end
endmodule
`default_nettype wire

### rtl/core/dlcb_checker.sv
// Port-level checker for the cross-basis FIR bank, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dlcb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_valid_res,
  input wire logic out_last,
  input wire logic signed [39:0] out_acc_value
);
  a_na_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_acc_value == 40'sd0) else $error("NA result nonzero");
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready) else $error("input ready mid-run");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_acc_value))
    else $error("stalled result changed");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind distributed_lag_cross_basis dlcb_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_valid_res(out_ch.valid_res),
  .out_last(out_ch.last), .out_acc_value(out_ch.acc_value)
);
`default_nettype wire

### tb/distributed_lag_cross_basis_test.sv
// Testbench: random and directed check of the cross-basis FIR bank against a scoreboard
`timescale 1ns / 1ps
module distributed_lag_cross_basis_test;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE_TICKS = 40;      // a load may still be in flight after the last result

  // one result of a sample run
  typedef struct {
    logic signed [39:0] acc;
    logic [1:0]         vi;
    logic [1:0]         bi;
    logic               vres;
    logic               last;
  } lag_sum_t;

  // Scoreboard: mirrors history ring, tap store and fill state; holds pending sums.
  class cross_basis_board;
    int       hist[dlcb_pkg::HISTORY_DEPTH][dlcb_pkg::NUM_VARS];
    int       coef[dlcb_pkg::HISTORY_DEPTH][dlcb_pkg::NUM_LAG_BASES];
    int       wr_slot;
    int       seen;
    int       lag;
    int       mismatches;
    lag_sum_t pending[$];

    function void note_request(bit fn, int tap, int lanes[4]);
      int       now;
      bit       ok;
      longint   acc;
      lag_sum_t s;
      if (fn == dlcb_pkg::FUNC_LOAD) begin
        for (int b = 0; b < dlcb_pkg::NUM_LAG_BASES; b++) coef[tap][b] = lanes[b];
        return;
      end
      now = wr_slot;
      for (int v = 0; v < dlcb_pkg::NUM_VARS; v++) hist[now][v] = lanes[v];
      ok = seen >= lag;
      wr_slot = (now + 1) % dlcb_pkg::HISTORY_DEPTH;
      if (seen < dlcb_pkg::HISTORY_DEPTH) seen++;
      for (int v = 0; v < dlcb_pkg::NUM_VARS; v++) begin
        for (int b = 0; b < dlcb_pkg::NUM_LAG_BASES; b++) begin
          acc = 0;
          if (ok) begin
            for (int k = 0; k <= lag; k++) begin
              acc += longint'(coef[k][b]) *
                     longint'(hist[(now + dlcb_pkg::HISTORY_DEPTH - k) %
                                   dlcb_pkg::HISTORY_DEPTH][v]);
              if (acc > 64'sd549755813887) acc = 64'sd549755813887;
              if (acc < -64'sd549755813888) acc = -64'sd549755813888;
            end
          end
          s.acc  = acc[39:0];
          s.vi   = 2'(v);
          s.bi   = 2'(b);
          s.vres = ok;
          s.last = (v == dlcb_pkg::NUM_VARS - 1) && (b == dlcb_pkg::NUM_LAG_BASES - 1);
          pending.push_back(s);
        end
      end
    endfunction

    function void check_result(lag_sum_t got);
      lag_sum_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result acc=%0d var=%0d basis=%0d", got.acc, got.vi, got.bi);
        return;
      end
      want = pending.pop_front();
      if (got.acc !== want.acc || got.vi !== want.vi || got.bi !== want.bi ||
          got.vres !== want.vres || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp acc=%0d v=%0d b=%0d ok=%0b last=%0b",
                    " | got acc=%0d v=%0d b=%0d ok=%0b last=%0b"},
                   want.acc, want.vi, want.bi, want.vres, want.last,
                   got.acc, got.vi, got.bi, got.vres, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [dlcb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  dlcb_in_if  in_ch ();
  dlcb_out_if out_ch ();

  distributed_lag_cross_basis u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  cross_basis_board board;
  bit  tap_loaded[dlcb_pkg::HISTORY_DEPTH];
  bit  calm;        // no idling on either side while set
  int  hold_ticks;  // receiver back-pressure stretch, counted down by the receiver
  int  cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge; long hold-off when requested.
  always begin
    @(negedge clk);
    if (hold_ticks > 0) begin
      hold_ticks = hold_ticks - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    lag_sum_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.acc  = out_ch.acc_value;
      got.vi   = out_ch.var_index;
      got.bi   = out_ch.basis_index;
      got.vres = out_ch.valid_res;
      got.last = out_ch.last;
      board.check_result(got);
    end
  end

  // Lane value with extra weight on the extremes
  function automatic int pick_lane();
    int r;
    r = $urandom_range(7);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    if (r == 2) return 0;
    return int'($signed(16'($urandom)));
  endfunction

  // One request; called right after a rising edge, returns at the accepting edge.
  task automatic send_request(bit fn, int tap, int lanes[4]);
    while (!calm && $urandom_range(99) < 27) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.tap_index <= tap[8:0];
    in_ch.lane_0    <= lanes[0][15:0];
    in_ch.lane_1    <= lanes[1][15:0];
    in_ch.lane_2    <= lanes[2][15:0];
    in_ch.lane_3    <= lanes[3][15:0];
    do @(posedge clk); while (!in_ch.ready);
    board.note_request(fn, tap, lanes);
    if (fn == dlcb_pkg::FUNC_LOAD) tap_loaded[tap] = 1'b1;
  endtask

  // Drain everything in flight, then leave room for a trailing load.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle.
  task automatic write_reg(logic [dlcb_pkg::CFG_ADDR_BITS-1:0] idx, int value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= dlcb_pkg::CFG_ADDR_BITS'(4 * idx);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == dlcb_pkg::REG_MAX_LAG) board.lag = value & 'h1FF;
  endtask

  // New lag setting, fill every tap the sweep will read, then random traffic.
  // heavy: full-scale taps and samples only.
  task automatic run_phase(int lag, int n, bit heavy);
    int lanes[4];
    settle();
    write_reg(dlcb_pkg::REG_MAX_LAG, lag);
    for (int k = 0; k <= lag; k++) begin
      if (heavy || !tap_loaded[k]) begin
        for (int i = 0; i < 4; i++) lanes[i] = heavy ? -32768 : pick_lane();
        send_request(dlcb_pkg::FUNC_LOAD, k, lanes);
      end
    end
    for (int j = 0; j < n; j++) begin
      if (heavy) begin
        for (int i = 0; i < 4; i++) lanes[i] = ($urandom_range(3) == 0) ? 32767 : -32768;
        send_request(dlcb_pkg::FUNC_SAMPLE, $urandom_range(511), lanes);
      end else begin
        for (int i = 0; i < 4; i++) lanes[i] = pick_lane();
        if ($urandom_range(99) < 70)
          send_request(dlcb_pkg::FUNC_SAMPLE, $urandom_range(511), lanes);
        else if ($urandom_range(1))
          send_request(dlcb_pkg::FUNC_LOAD, $urandom_range(lag), lanes);
        else
          send_request(dlcb_pkg::FUNC_LOAD, $urandom_range(511), lanes);
      end
    end
  endtask

  initial begin
    int lanes[4];
    board           = new();
    board.lag       = 0;
    cycles          = 0;
    calm            = 1'b0;
    hold_ticks      = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = dlcb_pkg::FUNC_LOAD;
    in_ch.tap_index = '0;
    in_ch.lane_0    = '0;
    in_ch.lane_1    = '0;
    in_ch.lane_2    = '0;
    in_ch.lane_3    = '0;
    out_ch.ready    = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Lag two straight out of reset: first two samples come back flagged NA with zero sums.
    write_reg(dlcb_pkg::REG_MAX_LAG, 2);
    for (int k = 0; k <= 2; k++) begin
      lanes = '{32767, -32768, k, -k};
      send_request(dlcb_pkg::FUNC_LOAD, k, lanes);
    end
    for (int j = 0; j < 4; j++) begin
      lanes = '{32767, -32768, j, -1};
      send_request(dlcb_pkg::FUNC_SAMPLE, 0, lanes);
    end
    // Lag zero: every sample is valid at once.
    settle();
    write_reg(dlcb_pkg::REG_MAX_LAG, 0);
    lanes = '{-32768, 32767, 0, -1};
    send_request(dlcb_pkg::FUNC_LOAD, 0, lanes);
    lanes = '{32767, 32767, 32767, 32767};
    send_request(dlcb_pkg::FUNC_SAMPLE, 0, lanes);
    lanes = '{-32768, -32768, -32768, -32768};
    send_request(dlcb_pkg::FUNC_SAMPLE, 511, lanes);
    lanes = '{1, -1, 21845, -21846};
    send_request(dlcb_pkg::FUNC_LOAD, 511, lanes);     // top tap, not read at this lag
    lanes = '{-1, 1, -21846, 21845};
    send_request(dlcb_pkg::FUNC_SAMPLE, 0, lanes);

    run_phase(3, 50, 1'b0);
    settle();
    hold_ticks = 1500;                 // receiver stalls while requests keep coming
    run_phase(1, 50, 1'b0);
    calm = 1'b1;
    run_phase(13, 50, 1'b0);
    calm = 1'b0;
    run_phase(40, 40, 1'b1);           // full-scale taps and samples over a longer span
    run_phase(0, 20, 1'b0);
    run_phase(6, 20, 1'b0);

    settle();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/core/dlcb_pkg.sv
rtl/core/dlcb_if.sv
rtl/core/dlcb_datapath.sv
rtl/core/dlcb_ctrl.sv
rtl/core/distributed_lag_cross_basis.sv
rtl/core/dlcb_checker.sv
tb/distributed_lag_cross_basis_test.sv
